FILE: design/es2utc_pkg.sv
// shared constants, types and small lookup functions for the epoch seconds to utc date block
// no dependencies

package es2utc_pkg;

    // default input width in bits
    localparam int SECONDS_WIDTH_DEF = 40;

    typedef logic [15:0] year_t;
    typedef logic [17:0] days_t;

    localparam days_t SECS_PER_DAY   = 18'd86400;
    localparam days_t DAYS_PER_400Y  = 18'd146097;
    localparam days_t DAYS_PER_100Y  = 18'd36524;
    localparam days_t DAYS_PER_4Y    = 18'd1461;
    localparam days_t DAYS_PER_YEAR  = 18'd365;
    localparam int    DAYS_0000_TO_1970 = 719468;
    localparam year_t YEAR_ORIGIN    = 16'd1900;

    // steps of the time-of-day unit: five hour bits, then six minute bits
    localparam logic [3:0] TOD_STEPS = 4'd11;
    localparam logic [3:0] HOUR_STEPS = 4'd5;

    // month lengths, counted from march
    function automatic days_t march_month_len(input logic [3:0] mp);
        days_t len;
        case (mp)
            4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: len = 18'd31;
            4'd1, 4'd3, 4'd6, 4'd8:                    len = 18'd30;
            default:                                   len = 18'd29;
        endcase
        return len;
    endfunction

    // trial subtrahend for each step of the hour/minute restoring division
    function automatic logic [16:0] tod_unit(input logic [3:0] step);
        logic [16:0] u;
        case (step)
            4'd0:    u = 17'd57600;
            4'd1:    u = 17'd28800;
            4'd2:    u = 17'd14400;
            4'd3:    u = 17'd7200;
            4'd4:    u = 17'd3600;
            4'd5:    u = 17'd1920;
            4'd6:    u = 17'd960;
            4'd7:    u = 17'd480;
            4'd8:    u = 17'd240;
            4'd9:    u = 17'd120;
            4'd10:   u = 17'd60;
            default: u = 17'd0;
        endcase
        return u;
    endfunction

    // weekday from day of era: an era is a whole number of weeks and
    // day zero of an era is a wednesday; 8 = 1 mod 7 so octal digits fold
    function automatic logic [2:0] weekday_from_doe(input days_t doe);
        logic [5:0] s;
        logic [3:0] t;
        logic [2:0] u;
        logic [3:0] w;
        s = 6'(doe[2:0]) + 6'(doe[5:3]) + 6'(doe[8:6]) + 6'(doe[11:9])
          + 6'(doe[14:12]) + 6'(doe[17:15]);
        t = 4'(s[5:3]) + 4'(s[2:0]);
        u = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
        w = 4'(u) + 4'd3;
        return (w >= 4'd7) ? 3'(w - 4'd7) : w[2:0];
    endfunction

endpackage

FILE: design/epoch_seconds_to_utc_date_top.sv
// epoch seconds to utc date converter, top level
// depends on es2utc_pkg

// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into the
// broken-down UTC date (second, minute, hour, day of month, month from zero,
// year minus 1900, weekday with Sunday as zero, day of year from zero), using
// the proleptic Gregorian calendar and floor semantics before the epoch.
// One item is in flight at a time. The time from input transfer to result
// grows with SECONDS_WIDTH and with the number of steps of the calendar walk.
// It is set by two bit-serial restoring divisions (seconds by 86400 over
// SECONDS_WIDTH-16 quotient bits, days by 146097 over SECONDS_WIDTH-17
// quotient bits) followed by a subtract-and-count walk over centuries,
// four-year blocks, years and months, one step per cycle. Hour and minute
// come from a small serial unit that runs alongside the second division.
// A finished result sits in the output register while the next item is
// accepted. If SECONDS_WIDTH is raised so far that the year leaves the
// 16-bit field, the year keeps its low 16 bits; all other fields stay
// exact.

module epoch_seconds_to_utc_date_top
    import es2utc_pkg::*;
#(
    parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SECONDS_WIDTH-1:0] s_epoch_seconds,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [5:0]                      m_second,
    output logic [5:0]                      m_minute,
    output logic [4:0]                      m_hour,
    output logic [4:0]                      m_day_of_month,
    output logic [3:0]                      m_month,
    output logic signed [15:0]              m_year_since_1900,
    output logic [2:0]                      m_weekday,
    output logic [8:0]                      m_day_of_year
);

    localparam int W = SECONDS_WIDTH;
    localparam int CNT_W = $clog2(SECONDS_WIDTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV1  = 4'd1;
    localparam logic [3:0] S_FIX1  = 4'd2;
    localparam logic [3:0] S_ZADD  = 4'd3;
    localparam logic [3:0] S_ZLOAD = 4'd4;
    localparam logic [3:0] S_DIV2  = 4'd5;
    localparam logic [3:0] S_FIX2  = 4'd6;
    localparam logic [3:0] S_ERA   = 4'd7;
    localparam logic [3:0] S_CENT  = 4'd8;
    localparam logic [3:0] S_QUAD  = 4'd9;
    localparam logic [3:0] S_YEAR  = 4'd10;
    localparam logic [3:0] S_MON   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       tcnt_reg, tcnt_next;
    logic             m_valid_reg, m_valid_next;

    // datapath
    logic [W-1:0]  num_reg;
    days_t         rem_reg;
    logic          neg_reg;
    logic [16:0]   tod_reg;
    logic [4:0]    hour_reg;
    logic [5:0]    minute_reg;
    days_t         wrem_reg;
    days_t         doe_reg;
    year_t         era_reg;
    logic [2:0]    wd_reg;
    logic [1:0]    c_reg;
    logic [4:0]    q4_reg;
    logic [1:0]    y1_reg;
    logic [3:0]    mp_reg;
    logic [8:0]    doy_reg;
    logic [8:0]    yoe_reg;

    // output registers
    logic [5:0]  m_second_reg;
    logic [5:0]  m_minute_reg;
    logic [4:0]  m_hour_reg;
    logic [4:0]  m_day_of_month_reg;
    logic [3:0]  m_month_reg;
    year_t       m_year_reg;
    logic [2:0]  m_weekday_reg;
    logic [8:0]  m_day_of_year_reg;

    logic          in_xfer;
    logic          out_load;
    logic [W-1:0]  in_mag;
    logic [W-1:0]  z_mag;
    days_t         divisor;
    logic [19:0]   div_diff;
    logic          div_ge;
    days_t         div_rem;
    logic [16:0]   tod_sub;
    logic          tod_ge;
    logic          leap;
    logic [8:0]    yday;
    logic [3:0]    month0;
    year_t         year;

    assign in_xfer = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // magnitudes of the two dividends
    assign in_mag = s_epoch_seconds[W-1] ? (~s_epoch_seconds + W'(1)) : s_epoch_seconds;
    assign z_mag  = num_reg[W-1] ? (~num_reg + W'(1)) : num_reg;

    // one restoring division step, shared by both divisions
    assign divisor  = (state_reg == S_DIV1) ? SECS_PER_DAY : DAYS_PER_400Y;
    assign div_diff = {1'b0, rem_reg, num_reg[W-1]} - {2'b00, divisor};
    assign div_ge   = !div_diff[19];
    assign div_rem  = div_ge ? div_diff[17:0] : {rem_reg[16:0], num_reg[W-1]};

    // one hour/minute trial subtraction
    assign tod_sub = tod_unit(tcnt_reg);
    assign tod_ge  = (tod_reg >= tod_sub);

    // final field assembly
    assign leap   = (y1_reg == 2'd0) && ((q4_reg != 5'd0) || (c_reg == 2'd0));
    assign yday   = (mp_reg < 4'd10) ? (doy_reg + 9'd59 + 9'(leap)) : (doy_reg - 9'd306);
    assign month0 = (mp_reg < 4'd10) ? (mp_reg + 4'd2) : (mp_reg - 4'd10);
    assign year   = era_reg + 16'(yoe_reg) + 16'(mp_reg >= 4'd10) - YEAR_ORIGIN;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tcnt_next    = tcnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (tcnt_reg < TOD_STEPS) begin
            tcnt_next = tcnt_reg + 4'd1;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_DIV1;
                    cnt_next   = CNT_W'(W - 16);
                end
            end
            S_DIV1: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_FIX1;
                end
            end
            S_FIX1: begin
                state_next = S_ZADD;
                tcnt_next  = 4'd0;
            end
            S_ZADD: begin
                state_next = S_ZLOAD;
            end
            S_ZLOAD: begin
                state_next = S_DIV2;
                cnt_next   = CNT_W'(W - 17);
            end
            S_DIV2: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_FIX2;
                end
            end
            S_FIX2: begin
                state_next = S_ERA;
            end
            S_ERA: begin
                state_next = S_CENT;
            end
            S_CENT: begin
                if (!(c_reg < 2'd3 && wrem_reg >= DAYS_PER_100Y)) begin
                    state_next = S_QUAD;
                end
            end
            S_QUAD: begin
                if (wrem_reg < DAYS_PER_4Y) begin
                    state_next = S_YEAR;
                end
            end
            S_YEAR: begin
                if (!(y1_reg < 2'd3 && wrem_reg >= DAYS_PER_YEAR)) begin
                    state_next = S_MON;
                end
            end
            S_MON: begin
                if (!(mp_reg < 4'd11 && wrem_reg >= march_month_len(mp_reg))) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tcnt_reg    <= TOD_STEPS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tcnt_reg    <= tcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hour and minute, one bit per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_FIX1) begin
            hour_reg   <= '0;
            minute_reg <= '0;
            if (neg_reg && (rem_reg != '0)) begin
                tod_reg <= 17'(SECS_PER_DAY - rem_reg);
            end else begin
                tod_reg <= rem_reg[16:0];
            end
        end else if (tcnt_reg < TOD_STEPS) begin
            if (tod_ge) begin
                tod_reg <= tod_reg - tod_sub;
            end
            if (tcnt_reg < HOUR_STEPS) begin
                hour_reg <= {hour_reg[3:0], tod_ge};
            end else begin
                minute_reg <= {minute_reg[4:0], tod_ge};
            end
        end
    end

    // division datapath and calendar walk
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    neg_reg <= s_epoch_seconds[W-1];
                    rem_reg <= {2'b00, in_mag[W-1:W-16]};
                    num_reg <= {in_mag[W-17:0], 16'b0};
                end
            end
            S_DIV1, S_DIV2: begin
                rem_reg <= div_rem;
                num_reg <= {num_reg[W-2:0], div_ge};
            end
            S_FIX1: begin
                // floor the day count before the epoch
                if (neg_reg) begin
                    num_reg <= (rem_reg == '0) ? (~num_reg + W'(1)) : ~num_reg;
                end
            end
            S_ZADD: begin
                num_reg <= num_reg + W'(DAYS_0000_TO_1970);
            end
            S_ZLOAD: begin
                neg_reg <= num_reg[W-1];
                rem_reg <= {1'b0, z_mag[W-1:W-17]};
                num_reg <= {z_mag[W-18:0], 17'b0};
            end
            S_FIX2: begin
                // floor the era, day of era from the remainder
                if (neg_reg) begin
                    era_reg <= ~num_reg[15:0] + 16'(rem_reg == '0);
                end else begin
                    era_reg <= num_reg[15:0];
                end
                if (neg_reg && (rem_reg != '0)) begin
                    wrem_reg <= DAYS_PER_400Y - rem_reg;
                    doe_reg  <= DAYS_PER_400Y - rem_reg;
                end else begin
                    wrem_reg <= rem_reg;
                    doe_reg  <= rem_reg;
                end
                c_reg  <= '0;
                q4_reg <= '0;
                y1_reg <= '0;
                mp_reg <= '0;
            end
            S_ERA: begin
                // era times 400 as shifts
                era_reg <= (era_reg << 8) + (era_reg << 7) + (era_reg << 4);
                wd_reg  <= weekday_from_doe(doe_reg);
            end
            S_CENT: begin
                if (c_reg < 2'd3 && wrem_reg >= DAYS_PER_100Y) begin
                    wrem_reg <= wrem_reg - DAYS_PER_100Y;
                    c_reg    <= c_reg + 2'd1;
                end
            end
            S_QUAD: begin
                if (wrem_reg >= DAYS_PER_4Y) begin
                    wrem_reg <= wrem_reg - DAYS_PER_4Y;
                    q4_reg   <= q4_reg + 5'd1;
                end
            end
            S_YEAR: begin
                if (y1_reg < 2'd3 && wrem_reg >= DAYS_PER_YEAR) begin
                    wrem_reg <= wrem_reg - DAYS_PER_YEAR;
                    y1_reg   <= y1_reg + 2'd1;
                end else begin
                    doy_reg <= wrem_reg[8:0];
                    yoe_reg <= 9'(c_reg) * 9'd100 + 9'({q4_reg, 2'b00}) + 9'(y1_reg);
                end
            end
            S_MON: begin
                if (mp_reg < 4'd11 && wrem_reg >= march_month_len(mp_reg)) begin
                    wrem_reg <= wrem_reg - march_month_len(mp_reg);
                    mp_reg   <= mp_reg + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_second_reg       <= tod_reg[5:0];
            m_minute_reg       <= minute_reg;
            m_hour_reg         <= hour_reg;
            m_day_of_month_reg <= 5'(wrem_reg) + 5'd1;
            m_month_reg        <= month0;
            m_year_reg         <= year;
            m_weekday_reg      <= wd_reg;
            m_day_of_year_reg  <= yday;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_second          = m_second_reg;
    assign m_minute          = m_minute_reg;
    assign m_hour            = m_hour_reg;
    assign m_day_of_month    = m_day_of_month_reg;
    assign m_month           = m_month_reg;
    assign m_year_since_1900 = m_year_reg;
    assign m_weekday         = m_weekday_reg;
    assign m_day_of_year     = m_day_of_year_reg;

    // time-of-day unit must finish before the era is resolved
    a_tod_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIX2) |-> (tcnt_reg == TOD_STEPS))
        else $error("hour/minute unit still busy at era fix");

    // after the year walk the remaining day count fits one year
    a_doy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MON) |-> (wrem_reg < 18'd366))
        else $error("day of year out of range in month walk");

    // a loaded result carries fields in range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_month <= 4'd11 && m_hour <= 5'd23 && m_minute <= 6'd59
                      && m_second <= 6'd59 && m_weekday <= 3'd6
                      && m_day_of_year <= 9'd365 && m_day_of_month != 5'd0))
        else $error("result field out of range");

endmodule
